FILE: design/qped_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_pkg
// Shared types, constants and helpers for the query parameter extractor.
// ----------------------------------------------------------------------------
package qped_pkg;

   localparam int MAX_KEY_BYTES_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;
   localparam int RESULTS_PER_ITEM      = 4;
   localparam int CSR_INDEX_W           = 2;
   localparam int CSR_DATA_W            = 64;

   localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'd1024;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_LOW      = 2'd0,
      REG_KEY_HIGH     = 2'd1,
      REG_KEY_LENGTH   = 2'd2,
      REG_OUTPUT_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_FOUND   = 2'd1,
      KIND_MISSING = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_NAME  = 2'd0,
      PHASE_SKIP  = 2'd1,
      PHASE_VALUE = 2'd2,
      PHASE_DONE  = 2'd3
   } phase_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [1:0]                            last_idx;
      logic [RESULTS_PER_ITEM-1:0][7:0]      bytes;
      kind_type [RESULTS_PER_ITEM-1:0]       kinds;
   } entry_type;

   function automatic logic is_hex(input logic [7:0] b);
      logic r;
      case (b) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
         default:                                     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] r;
      case (b) inside
         [8'h30:8'h39]:               r = b[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: r = b[3:0] + 4'd9;
         default:                     r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/qped_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_front
// Holds the configuration, tracks name matching and percent decoding, and
// packs all results of one accepted byte into a single queue entry.
// ----------------------------------------------------------------------------
module qped_front
   import qped_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   accept,
   input  logic [7:0]             query_byte,
   input  logic                   query_last,
   output logic                   entry_valid,
   output entry_type              entry
);

   localparam logic [4:0] MAX_KEY = 5'(MAX_KEY_BYTES);

   logic [MAX_KEY_BYTES-1:0][7:0] key_ff;
   logic [4:0]                    key_length_ff;
   logic [15:0]                   output_limit_ff;

   phase_type   phase_ff, phase_in;
   logic [4:0]  name_pos_ff, name_pos_in;
   logic        mismatch_ff, mismatch_in;
   logic [15:0] value_count_ff, value_count_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic [7:0]  pend_digit_ff, pend_digit_in;

   logic        is_amp, is_equal, is_percent, is_plus, b_hex;
   logic        in_value, value_byte_step;
   logic        esc_digit1, esc_pair, esc_broken, plain_byte;
   logic [15:0] value_count_inc;
   logic        limit_hit, value_end, final_flush, name_hit;
   logic [1:0]  pend_count_dec;
   logic [7:0]  pend_digit_dec;
   logic [7:0]  key_sel;
   phase_type   step_phase;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff          <= '0;
         key_length_ff   <= '0;
         output_limit_ff <= OUTPUT_LIMIT_RESET;
      end else if (csr_write) begin
         for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if ((i < 8 && csr_index == REG_KEY_LOW) ||
                (i >= 8 && csr_index == REG_KEY_HIGH)) begin
               key_ff[i] <= csr_data[8*(i%8) +: 8];
            end
         end
         if (csr_index == REG_KEY_LENGTH) begin
            key_length_ff <= csr_data[4:0];
         end
         if (csr_index == REG_OUTPUT_LIMIT) begin
            output_limit_ff <= csr_data[15:0];
         end
      end
   end

   assign is_amp     = (query_byte == CH_AMP);
   assign is_equal   = (query_byte == CH_EQUAL);
   assign is_percent = (query_byte == CH_PERCENT);
   assign is_plus    = (query_byte == CH_PLUS);
   assign b_hex      = is_hex(query_byte);

   always_comb begin
      key_sel = '0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (name_pos_ff == 5'(i)) begin
            key_sel = key_ff[i];
         end
      end
   end

   assign name_hit = !mismatch_ff && (key_length_ff != '0) && (key_length_ff <= MAX_KEY) &&
                     (name_pos_ff == key_length_ff) && (output_limit_ff != '0);

   // value decode classification
   assign in_value        = (phase_ff == PHASE_VALUE);
   assign value_byte_step = in_value && !is_amp;
   assign esc_digit1      = value_byte_step && (pend_count_ff == 2'd1) && b_hex;
   assign esc_pair        = value_byte_step && (pend_count_ff == 2'd2) && b_hex;
   assign esc_broken      = value_byte_step && (pend_count_ff != 2'd0) && !b_hex;
   assign plain_byte      = value_byte_step && !esc_digit1 && !esc_pair;

   assign value_count_inc = value_count_ff + 16'd1;
   // a zero limit written mid-value never ends the value by count
   assign limit_hit       = value_byte_step && (output_limit_ff != '0) &&
                            (value_count_inc >= output_limit_ff - 16'd1);
   assign value_end       = (in_value && is_amp) || limit_hit;

   always_comb begin
      pend_count_dec = pend_count_ff;
      pend_digit_dec = pend_digit_ff;
      if (esc_digit1) begin
         pend_count_dec = 2'd2;
         pend_digit_dec = query_byte;
      end else if (esc_pair) begin
         pend_count_dec = 2'd0;
      end else if (plain_byte) begin
         pend_count_dec = is_percent ? 2'd1 : 2'd0;
      end
   end

   // phase after the byte itself, before end-of-query handling
   always_comb begin
      step_phase = phase_ff;
      case (phase_ff)
         PHASE_NAME: begin
            if (is_equal) begin
               if (!name_hit) begin
                  step_phase = PHASE_SKIP;
               end else if (output_limit_ff <= 16'd1) begin
                  step_phase = PHASE_DONE;
               end else begin
                  step_phase = PHASE_VALUE;
               end
            end
         end
         PHASE_SKIP:  if (is_amp) step_phase = PHASE_NAME;
         PHASE_VALUE: if (value_end) step_phase = PHASE_DONE;
         default:     step_phase = phase_ff;
      endcase
   end

   assign final_flush = value_end || (query_last && step_phase == PHASE_VALUE);

   // next state
   always_comb begin
      phase_in       = step_phase;
      name_pos_in    = name_pos_ff;
      mismatch_in    = mismatch_ff;
      value_count_in = value_count_ff;
      pend_count_in  = pend_count_ff;
      pend_digit_in  = pend_digit_ff;
      case (phase_ff)
         PHASE_NAME: begin
            if (is_amp && name_pos_ff == '0) begin
               // leading separator
            end else if (is_equal) begin
               name_pos_in = '0;
               mismatch_in = 1'b0;
               if (name_hit) begin
                  value_count_in = '0;
                  pend_count_in  = '0;
               end
            end else begin
               if (name_pos_ff >= key_length_ff || name_pos_ff >= MAX_KEY ||
                   key_sel != query_byte) begin
                  mismatch_in = 1'b1;
               end
               if (name_pos_ff != 5'd31) begin
                  name_pos_in = name_pos_ff + 5'd1;
               end
            end
         end
         PHASE_VALUE: begin
            pend_digit_in = pend_digit_dec;
            pend_count_in = final_flush ? 2'd0 : pend_count_dec;
            if (value_byte_step) begin
               value_count_in = value_count_inc;
            end
         end
         default: ;
      endcase
      if (query_last) begin
         phase_in       = PHASE_NAME;
         name_pos_in    = '0;
         mismatch_in    = 1'b0;
         value_count_in = '0;
         pend_count_in  = '0;
         pend_digit_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_NAME;
         name_pos_ff    <= '0;
         mismatch_ff    <= 1'b0;
         value_count_ff <= '0;
         pend_count_ff  <= '0;
         pend_digit_ff  <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         name_pos_ff    <= name_pos_in;
         mismatch_ff    <= mismatch_in;
         value_count_ff <= value_count_in;
         pend_count_ff  <= pend_count_in;
         pend_digit_ff  <= pend_digit_in;
      end
   end

   // result packing, in emission order
   always_comb begin
      logic [2:0] n;
      n           = '0;
      entry.bytes = '0;
      for (int i = 0; i < RESULTS_PER_ITEM; i++) begin
         entry.kinds[i] = KIND_BYTE;
      end
      if (esc_broken) begin
         entry.bytes[n[1:0]] = CH_PERCENT;
         n = n + 3'd1;
         if (pend_count_ff == 2'd2) begin
            entry.bytes[n[1:0]] = pend_digit_ff;
            n = n + 3'd1;
         end
      end
      if (esc_pair) begin
         entry.bytes[n[1:0]] = {hex_value(pend_digit_ff), hex_value(query_byte)};
         n = n + 3'd1;
      end else if (plain_byte && !is_percent) begin
         entry.bytes[n[1:0]] = is_plus ? CH_SPACE : query_byte;
         n = n + 3'd1;
      end
      if (final_flush) begin
         if (pend_count_dec != 2'd0) begin
            entry.bytes[n[1:0]] = CH_PERCENT;
            n = n + 3'd1;
         end
         if (pend_count_dec == 2'd2) begin
            entry.bytes[n[1:0]] = pend_digit_dec;
            n = n + 3'd1;
         end
      end
      if (query_last) begin
         entry.kinds[n[1:0]] = (step_phase == PHASE_VALUE || step_phase == PHASE_DONE) ?
                               KIND_FOUND : KIND_MISSING;
         n = n + 3'd1;
      end
      entry.last_idx = 2'(n - 3'd1);
      entry_valid    = accept && (n != '0);
   end

endmodule

FILE: design/qped_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_fifo
// Short entry queue between the decode front and the result serializer.
// ----------------------------------------------------------------------------
module qped_fifo
   import qped_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type pop_data,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   CNT_MAX = (PTR_W+1)'(QUEUE_DEPTH);

   entry_type            mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_MAX);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_MAX) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_MAX) ? '0 : head_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_data;
      end
   end

endmodule

FILE: design/qped_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_back
// Holds one queue entry and hands its results out one per transaction.
// ----------------------------------------------------------------------------
module qped_back
   import qped_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  entry_type  queue_data,
   output logic       queue_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_value_byte,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_run_last
);

   entry_type  cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       take, at_last;

   assign take    = rsp_pop && valid_ff;
   assign at_last = (idx_ff == cur_ff.last_idx);

   always_comb begin
      cur_in    = cur_ff;
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      queue_pop = 1'b0;
      if (!valid_ff || (take && at_last)) begin
         queue_pop = !queue_empty;
         valid_in  = !queue_empty;
         cur_in    = queue_data;
         idx_in    = '0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_value_byte  = cur_ff.bytes[idx_ff];
   assign rsp_result_kind = cur_ff.kinds[idx_ff];
   assign rsp_run_last    = at_last;

endmodule

FILE: design/query_parameter_extract_decode_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_parameter_extract_decode_core
// Finds one configured key in a URL query byte stream and returns its
// percent-decoded value followed by a found / not-found status.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction  handshake
//  req       req_query_byte, req_query_last          in         push / full
//  rsp       rsp_value_byte, rsp_result_kind,        out        pop / empty
//            rsp_run_last
//  csr       csr_index, csr_data                     in         valid / ready
//
//  One byte is taken per cycle while req_full is low. Each byte that yields
//  results becomes one queue entry; the serializer drains it at one result
//  per cycle while rsp_pop is high; a byte yields k results (k up to 4).
//  First result passes through the queue, then the serializer's register.
//  req_full rises only when the entry queue is full; csr_ready is always high.
//  Synchronous reset clears the query state, key registers and the queue.
// ----------------------------------------------------------------------------
module query_parameter_extract_decode_core
   import qped_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_query_byte,
   input  logic                   req_query_last,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_value_byte,
   output logic [1:0]             rsp_result_kind,
   output logic                   rsp_run_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic      accept;
   logic      entry_valid;
   entry_type entry;
   entry_type queue_data;
   logic      queue_pop, queue_empty;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   qped_front #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .accept      (accept),
      .query_byte  (req_query_byte),
      .query_last  (req_query_last),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   qped_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_valid),
      .push_data (entry),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .full      (req_full),
      .empty     (queue_empty)
   );

   qped_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_data      (queue_data),
      .queue_pop       (queue_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_result_kind (rsp_result_kind),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for query_parameter_extract_decode_core. Query strings
// are pushed byte by byte, a behavioral decoder predicts every value byte and
// status, and each popped result is compared in order. Runs directed queries,
// random queries under several idle patterns, extreme register settings and
// a long output stall.
// ----------------------------------------------------------------------------
module testbench;
   import qped_pkg::*;

   localparam int          KEY_BYTES_MAX = 16;
   localparam int          QUIET_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES = 6;
   localparam logic [63:0] KEY_AB        = 64'h6261;

   typedef struct {
      logic [7:0] value;
      kind_type   kind;
      logic       run_last;
   } query_result_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_push       = 1'b0;
   logic                   req_full;
   logic [7:0]             req_query_byte = '0;
   logic                   req_query_last = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop        = 1'b0;
   logic [7:0]             rsp_value_byte;
   logic [1:0]             rsp_result_kind;
   logic                   rsp_run_last;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // decoder model: registers and per-query state
   logic [63:0] key_lo      = '0;
   logic [63:0] key_hi      = '0;
   logic [4:0]  key_len     = '0;
   logic [15:0] out_lim     = OUTPUT_LIMIT_RESET;
   phase_type   scan_phase  = PHASE_NAME;
   int          name_pos    = 0;
   logic        name_bad    = 1'b0;
   int          value_count = 0;
   int          esc_count   = 0;
   logic [7:0]  esc_digit   = '0;

   query_result_type byte_results[$];
   query_result_type decode_results[$];
   logic [7:0]       query_bytes[$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   query_parameter_extract_decode_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_query_byte  (req_query_byte),
      .req_query_last  (req_query_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_value_byte  (rsp_value_byte),
      .rsp_result_kind (rsp_result_kind),
      .rsp_run_last    (rsp_run_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] key_char(input int i);
      return (i < 8) ? key_lo[i*8 +: 8] : key_hi[(i-8)*8 +: 8];
   endfunction

   function automatic void add_result(input logic [7:0] v, input kind_type k);
      byte_results.push_back('{value: v, kind: k, run_last: 1'b0});
   endfunction

   // value ended inside an escape: '%' and any digit go out literally
   function automatic void flush_escape();
      if (esc_count >= 1) add_result(CH_PERCENT, KIND_BYTE);
      if (esc_count >= 2) add_result(esc_digit, KIND_BYTE);
      esc_count = 0;
   endfunction

   function automatic void decode_value_byte(input logic [7:0] b);
      int h;
      int hi;
      h = hex_nibble(b);
      if (esc_count == 1) begin
         if (h >= 0) begin
            esc_digit = b;
            esc_count = 2;
            return;
         end
         flush_escape();
      end else if (esc_count == 2) begin
         if (h >= 0) begin
            hi = hex_nibble(esc_digit);
            add_result(8'(hi * 16 + h), KIND_BYTE);
            esc_count = 0;
            return;
         end
         flush_escape();
      end
      if (b == CH_PERCENT) esc_count = 1;
      else if (b == CH_PLUS) add_result(CH_SPACE, KIND_BYTE);
      else add_result(b, KIND_BYTE);
   endfunction

   function automatic void decode_query_byte(input logic [7:0] b, input logic last);
      logic hit;
      byte_results.delete();
      case (scan_phase)
         PHASE_NAME: begin
            // leading '&' of a segment is dropped, later ones are name bytes
            if (!(b == CH_AMP && name_pos == 0)) begin
               if (b == CH_EQUAL) begin
                  hit = !name_bad && key_len != 0 && key_len <= KEY_BYTES_MAX &&
                        name_pos == key_len && out_lim != 0;
                  name_pos = 0;
                  name_bad = 1'b0;
                  if (hit) begin
                     value_count = 0;
                     esc_count   = 0;
                     scan_phase  = (out_lim <= 1) ? PHASE_DONE : PHASE_VALUE;
                  end else begin
                     scan_phase = PHASE_SKIP;
                  end
               end else begin
                  if (name_pos >= key_len || name_pos >= KEY_BYTES_MAX ||
                      key_char(name_pos) != b)
                     name_bad = 1'b1;
                  if (name_pos < 31) name_pos++;
               end
            end
         end
         PHASE_SKIP: begin
            if (b == CH_AMP) scan_phase = PHASE_NAME;
         end
         PHASE_VALUE: begin
            if (b == CH_AMP) begin
               flush_escape();
               scan_phase = PHASE_DONE;
            end else begin
               decode_value_byte(b);
               value_count++;
               if (value_count >= int'(out_lim) - 1) begin
                  flush_escape();
                  scan_phase = PHASE_DONE;
               end
            end
         end
         default: ;
      endcase
      if (last) begin
         if (scan_phase == PHASE_VALUE) begin
            flush_escape();
            add_result('0, KIND_FOUND);
         end else if (scan_phase == PHASE_DONE) begin
            add_result('0, KIND_FOUND);
         end else begin
            add_result('0, KIND_MISSING);
         end
         scan_phase  = PHASE_NAME;
         name_pos    = 0;
         name_bad    = 1'b0;
         value_count = 0;
         esc_count   = 0;
         esc_digit   = '0;
      end
      if (byte_results.size() > 0) byte_results[byte_results.size()-1].run_last = 1'b1;
      foreach (byte_results[i]) decode_results.push_back(byte_results[i]);
   endfunction

   // ------------------------------------------------------------------------
   // checking, output side, watchdog
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t MISMATCH: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_results
      query_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (decode_results.size() == 0) begin
            report_mismatch($sformatf("result with none pending: byte %02h kind %0d last %0b",
                                      rsp_value_byte, rsp_result_kind, rsp_run_last));
         end else begin
            want = decode_results.pop_front();
            if (rsp_value_byte !== want.value || rsp_result_kind !== want.kind ||
                rsp_run_last !== want.run_last)
               report_mismatch($sformatf(
                  "got byte %02h kind %0d last %0b, expected byte %02h kind %0d last %0b",
                  rsp_value_byte, rsp_result_kind, rsp_run_last,
                  want.value, want.kind, want.run_last));
         end
      end
   end

   // output side: random stalls, plus a counted hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("query_parameter_extract_decode_core test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_query_byte <= b;
      req_query_last <= last;
      do @(posedge clock); while (req_full);
      decode_query_byte(b, last);
      items_sent++;
   endtask

   task automatic send_query();
      foreach (query_bytes[i]) send_byte(query_bytes[i], i == query_bytes.size() - 1);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (decode_results.size() != 0) @(posedge clock);
      // bytes with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_KEY_LOW:    key_lo  = data;
         REG_KEY_HIGH:   key_hi  = data;
         REG_KEY_LENGTH: key_len = data[4:0];
         default:        out_lim = data[15:0];
      endcase
   endtask

   task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic [15:0] lim);
      wait_idle();
      write_register(REG_KEY_LOW, lo);
      write_register(REG_KEY_HIGH, hi);
      write_register(REG_KEY_LENGTH, 64'(len));
      write_register(REG_OUTPUT_LIMIT, 64'(lim));
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
         default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // query generation
   // ------------------------------------------------------------------------
   function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == avoid);
      return b;
   endfunction

   function automatic logic [7:0] hex_char();
      int idx;
      idx = $urandom_range(21);
      if (idx < 10) return 8'("0" + idx);
      if (idx < 16) return 8'("a" + idx - 10);
      return 8'("A" + idx - 16);
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0 || b == CH_AMP);
      return b;
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) query_bytes.push_back(s[i]);
   endfunction

   function automatic void add_value_piece();
      int k;
      k = $urandom_range(19);
      if (k < 5) begin
         query_bytes.push_back(CH_PERCENT);
         query_bytes.push_back(hex_char());
         query_bytes.push_back(hex_char());
      end else if (k < 7) begin
         query_bytes.push_back(CH_PERCENT);
         query_bytes.push_back(hex_char());
         query_bytes.push_back(non_hex_char());
      end else if (k < 9) begin
         query_bytes.push_back(CH_PERCENT);
         query_bytes.push_back(any_byte_but(CH_AMP));
      end else if (k < 11) begin
         query_bytes.push_back(CH_PLUS);
      end else begin
         query_bytes.push_back(any_byte_but(CH_AMP));
      end
   endfunction

   // mostly name=value segments built around the key, some raw noise
   function automatic void build_random_query();
      int key_use;
      int segs;
      int pick;
      int n;
      query_bytes.delete();
      key_use = (key_len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : int'(key_len);
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            pick = $urandom_range(9);
            if (pick < 2) query_bytes.push_back(CH_EQUAL);
            else if (pick < 4) query_bytes.push_back(CH_AMP);
            else query_bytes.push_back(8'($urandom_range(255)));
         end
         return;
      end
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
         if (s > 0 || $urandom_range(3) == 0) query_bytes.push_back(CH_AMP);
         pick = $urandom_range(9);
         if (pick < 7) begin
            for (int i = 0; i < key_use; i++) query_bytes.push_back(key_char(i));
            // near miss: one extra byte or one flipped bit
            if (pick >= 5) begin
               if ($urandom_range(1) == 0 || key_use == 0)
                  query_bytes.push_back(any_byte_but(CH_EQUAL));
               else
                  query_bytes[query_bytes.size()-1] ^= 8'(1 << $urandom_range(7));
            end
         end else begin
            n = $urandom_range(0, 4);
            repeat (n) query_bytes.push_back(any_byte_but(CH_EQUAL));
         end
         if ($urandom_range(9) != 0) query_bytes.push_back(CH_EQUAL);
         n = $urandom_range(0, 6);
         repeat (n) add_value_piece();
      end
      if (query_bytes.size() == 0) query_bytes.push_back(8'($urandom_range(255)));
   endfunction

   task automatic send_random(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) begin
         build_random_query();
         // cut the query so the byte budget is kept
         while (query_bytes.size() > count - (items_sent - start))
            void'(query_bytes.pop_back());
         send_query();
      end
   endtask

   task automatic send_text(input string s);
      query_bytes.delete();
      add_text(s);
      send_query();
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_queries();
      set_config(KEY_AB, '0, 5'd2, 16'd1024);
      set_idle_mode(0);
      // leading '&', hex escape, broken escape, '+'
      send_text("&ab=%4a%z+");
      // query ends right after '%'
      send_text("ab=%");
      // other name skipped, last segment without '='
      query_bytes.delete();
      add_text("c=");
      query_bytes.push_back(8'hFF);
      add_text("&ab");
      send_query();
      // byte extremes, then escape broken by the last byte (four results)
      query_bytes.delete();
      add_text("ab=");
      query_bytes.push_back(8'hFF);
      query_bytes.push_back(8'h00);
      add_text("%4z");
      send_query();
   endtask

   task automatic test_idle_phases();
      for (int m = 0; m < 4; m++) begin
         set_config({$urandom, $urandom}, {$urandom, $urandom},
                    5'($urandom_range(1, 16)),
                    ($urandom_range(3) == 0) ? 16'd1024 : 16'($urandom_range(2, 24)));
         set_idle_mode(m);
         send_random(9);
      end
   endtask

   task automatic run_setting(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic [15:0] lim);
      set_config(lo, hi, len, lim);
      set_idle_mode($urandom_range(3));
   endtask

   task automatic test_config_extremes();
      run_setting('1, '1, 5'd16, 16'hFFFF);
      // name far longer than the key saturates its position
      query_bytes.delete();
      repeat (34) query_bytes.push_back(8'hFF);
      query_bytes.push_back(CH_EQUAL);
      add_text("x");
      send_query();
      send_random(4);
      run_setting('0, '0, 5'd16, 16'd1024);
      send_random(3);
      run_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 16'd1024);
      send_random(3);
      run_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 16'd1024);
      send_random(3);
      run_setting({$urandom, $urandom}, {$urandom, $urandom}, 5'd31, 16'd1024);
      send_random(3);
      run_setting(KEY_AB, '0, 5'd2, 16'd0);
      send_random(3);
      run_setting(KEY_AB, '0, 5'd2, 16'd1);
      send_text("ab=xy");
      send_random(3);
      run_setting(KEY_AB, '0, 5'd2, 16'd2);
      send_random(3);
      run_setting(KEY_AB, '0, 5'd2, 16'd3);
      // empty value, then raw byte limit hit inside an escape
      send_text("ab=&x");
      send_text("ab=%41x");
      send_random(3);
   endtask

   task automatic test_backpressure();
      set_config(KEY_AB, '0, 5'd2, 16'd1024);
      set_idle_mode(0);
      hold_request = 150;
      query_bytes.delete();
      add_text("ab=");
      repeat (12) begin
         query_bytes.push_back(8'($urandom_range(8'h30, 8'h7E)));
      end
      send_query();
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_queries();
      test_idle_phases();
      test_config_extremes();
      test_backpressure();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("query_parameter_extract_decode_core test passed");
      end else begin
         $display("query_parameter_extract_decode_core test failed");
      end
      $finish;
   end

endmodule
